FILE: src/nspc_pkg.sv
// Package for the nearest-seed pixel colorer.
// Holds the item type that moves down the cell chain and the shared codes.
// No dependencies.
package nspc_pkg;

    localparam int MAX_SEEDS  = 16;
    localparam int COORD_BITS = 12;

    localparam int COORD_W = COORD_BITS;
    localparam int IDX_W   = 4;
    localparam int COLOR_W = 32;
    localparam int SQ_W    = 2 * COORD_W;
    localparam int DIST_W  = SQ_W + 1;

    localparam logic KIND_SEED  = 1'b0;
    localparam logic KIND_PIXEL = 1'b1;

    localparam logic CFG_SEED_COUNT  = 1'b0;
    localparam logic CFG_EMPTY_COLOR = 1'b1;

    localparam logic [COLOR_W-1:0] EMPTY_COLOR_RESET = 32'hFF00_0000;

    typedef struct packed {
        logic               valid;
        logic               kind;
        logic [IDX_W-1:0]   idx;
        logic [COORD_W-1:0] x;
        logic [COORD_W-1:0] y;
        logic [COLOR_W-1:0] color;
        logic [DIST_W-1:0]  best_dsq;
        logic               found;
    } item_t;

endpackage

FILE: src/nearest_seed_pixel_colorer.sv
// Top level of the nearest-seed pixel colorer.
// Builds the chain of nspc_cell instances, the configuration registers and the output register.
// Depends on nspc_pkg and nspc_cell.
//
// Usage:
// The slave stream carries one item per transfer. s_tuser is the kind: 0 stores a seed
// (seed_index, seed_x, seed_y, seed_color), 1 queries a pixel (pixel_x, pixel_y).
// A seed store gives no result. A pixel query gives one master transfer with the color
// of the nearest seed on m_tdata and the found flag on m_tuser; on equal distance the
// lower seed index wins, and with seed_count zero the empty color is returned.
// Items travel through one cell per seed, two register stages per cell, so one item is
// taken every cycle unless the receiver stalls. Seed stores travel down the same chain,
// so every query sees exactly the seeds stored before it. Registers are written through
// cfg_we, cfg_index and cfg_wdata while idle; the user must keep to that, as the block
// does not enforce it. Reset empties the chain and the output register, clears seed_count
// and sets the empty color to opaque black; seed entries are undefined until stored. When
// the receiver stalls the whole chain holds and s_tready falls until the result is taken.
module nearest_seed_pixel_colorer (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    // seed_index[3:0], seed_x[15:4], seed_y[27:16], seed_color[59:28],
    // pixel_x[71:60], pixel_y[83:72], zero fill [87:84]
    input  logic [87:0] s_tdata,
    // kind[0]
    input  logic        s_tuser,
    output logic        m_tvalid,
    input  logic        m_tready,
    // pixel_color[31:0]
    output logic [31:0] m_tdata,
    // seed_found[0]
    output logic        m_tuser,
    input  logic        cfg_we,
    input  logic        cfg_index,
    input  logic [31:0] cfg_wdata
);

    logic [4:0]                   seed_count_reg;
    logic [nspc_pkg::COLOR_W-1:0] empty_color_reg;
    logic                         m_tvalid_reg;
    logic [nspc_pkg::COLOR_W-1:0] m_tdata_reg;
    logic                         m_tuser_reg;
    logic                         adv;

    nspc_pkg::item_t chain [0:nspc_pkg::MAX_SEEDS];

    assign adv      = !m_tvalid_reg || m_tready;
    assign s_tready = adv;

    always_comb begin
        chain[0].valid    = s_tvalid;
        chain[0].kind     = s_tuser;
        chain[0].idx      = s_tdata[3:0];
        chain[0].best_dsq = '0;
        chain[0].found    = 1'b0;
        if (s_tuser == nspc_pkg::KIND_SEED) begin
            chain[0].x     = s_tdata[15:4];
            chain[0].y     = s_tdata[27:16];
            chain[0].color = s_tdata[59:28];
        end else begin
            chain[0].x     = s_tdata[71:60];
            chain[0].y     = s_tdata[83:72];
            chain[0].color = empty_color_reg;
        end
    end

    for (genvar i = 0; i < nspc_pkg::MAX_SEEDS; i++) begin : g_cell
        nspc_cell #(
            .CELL_IDX(i)
        ) u_cell (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .adv       (adv),
            .seed_count(seed_count_reg),
            .item_in   (chain[i]),
            .item_out  (chain[i+1])
        );
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            seed_count_reg  <= '0;
            empty_color_reg <= nspc_pkg::EMPTY_COLOR_RESET;
        end else if (cfg_we) begin
            unique case (cfg_index)
                nspc_pkg::CFG_SEED_COUNT:  seed_count_reg  <= cfg_wdata[4:0];
                nspc_pkg::CFG_EMPTY_COLOR: empty_color_reg <= cfg_wdata;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (adv) begin
            m_tvalid_reg <= chain[nspc_pkg::MAX_SEEDS].valid &&
                            chain[nspc_pkg::MAX_SEEDS].kind == nspc_pkg::KIND_PIXEL;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            m_tdata_reg <= chain[nspc_pkg::MAX_SEEDS].color;
            m_tuser_reg <= chain[nspc_pkg::MAX_SEEDS].found;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

`ifndef NO_ASSERTIONS
    a_reset_empty: assert property (@(posedge aclk) $past(!aresetn) |-> !m_tvalid)
        else $error("output valid right after reset");

    a_query_delivered: assert property (@(posedge aclk) disable iff (!aresetn)
        (adv && chain[nspc_pkg::MAX_SEEDS].valid &&
         chain[nspc_pkg::MAX_SEEDS].kind == nspc_pkg::KIND_PIXEL)
        |=> m_tvalid)
        else $error("query leaving the chain was not presented");

    a_no_spurious: assert property (@(posedge aclk) disable iff (!aresetn)
        (adv && !(chain[nspc_pkg::MAX_SEEDS].valid &&
                  chain[nspc_pkg::MAX_SEEDS].kind == nspc_pkg::KIND_PIXEL))
        |=> !m_tvalid)
        else $error("result presented without a query");
`endif

endmodule

FILE: src/nspc_cell.sv
// One cell of the seed chain: holds one seed and updates the best match of passing pixels.
// Two register stages per cell: squared differences, then sum and compare.
// Depends on nspc_pkg.
module nspc_cell #(
    parameter int CELL_IDX = 0
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          adv,
    input  logic [4:0]    seed_count,
    input  nspc_pkg::item_t item_in,
    output nspc_pkg::item_t item_out
);

    logic [nspc_pkg::COORD_W-1:0] seed_x_reg;
    logic [nspc_pkg::COORD_W-1:0] seed_y_reg;
    logic [nspc_pkg::COLOR_W-1:0] seed_color_reg;

    nspc_pkg::item_t a_reg;
    nspc_pkg::item_t b_reg;
    nspc_pkg::item_t b_next;

    logic [nspc_pkg::SQ_W-1:0]    sqx_reg;
    logic [nspc_pkg::SQ_W-1:0]    sqy_reg;
    logic [nspc_pkg::COLOR_W-1:0] cand_color_reg;

    logic [nspc_pkg::COORD_W-1:0] dx;
    logic [nspc_pkg::COORD_W-1:0] dy;
    logic [nspc_pkg::DIST_W-1:0]  sum;
    logic                         active;
    logic                         take;

    assign active = 32'(seed_count) > 32'(CELL_IDX);

    always_ff @(posedge aclk) begin
        if (adv && item_in.valid && item_in.kind == nspc_pkg::KIND_SEED &&
            32'(item_in.idx) == 32'(CELL_IDX)) begin
            seed_x_reg     <= item_in.x;
            seed_y_reg     <= item_in.y;
            seed_color_reg <= item_in.color;
        end
    end

    always_comb begin
        dx = (item_in.x >= seed_x_reg) ? item_in.x - seed_x_reg : seed_x_reg - item_in.x;
        dy = (item_in.y >= seed_y_reg) ? item_in.y - seed_y_reg : seed_y_reg - item_in.y;
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            sqx_reg        <= nspc_pkg::SQ_W'(dx) * nspc_pkg::SQ_W'(dx);
            sqy_reg        <= nspc_pkg::SQ_W'(dy) * nspc_pkg::SQ_W'(dy);
            cand_color_reg <= seed_color_reg;
        end
    end

    always_comb begin
        sum  = {1'b0, sqx_reg} + {1'b0, sqy_reg};
        take = a_reg.valid && a_reg.kind == nspc_pkg::KIND_PIXEL && active &&
               (!a_reg.found || sum < a_reg.best_dsq);
        b_next = a_reg;
        if (take) begin
            b_next.color    = cand_color_reg;
            b_next.best_dsq = sum;
            b_next.found    = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_reg.valid <= 1'b0;
            b_reg.valid <= 1'b0;
        end else if (adv) begin
            a_reg <= item_in;
            b_reg <= b_next;
        end
    end

    assign item_out = b_reg;

endmodule

FILE: sim/tb_top.sv
// Testbench for nearest_seed_pixel_colorer: a directed table, mostly with fixed results,
// then random seed stores and pixel queries checked by a nearest-seed bench predictor.
// Depends on nspc_pkg and the RTL of nearest_seed_pixel_colorer.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int SEEDS       = 16;
    localparam int SETTLE      = 2 * SEEDS + 8;
    localparam int CYCLE_LIMIT = 400000;
    localparam int PHASES      = 10;
    localparam int PHASE_ITEMS = 52;

    typedef struct packed {
        logic [31:0] color;
        logic        found;
    } shade_t;

    typedef struct packed {
        bit          is_reg;
        logic        reg_idx;
        logic [31:0] reg_val;
        logic        kind;
        logic [3:0]  idx;
        logic [11:0] sx;
        logic [11:0] sy;
        logic [31:0] col;
        logic [11:0] px;
        logic [11:0] py;
        bit          typed;
        shade_t      want;
    } plan_row_t;

    logic        aclk = 1'b0;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [87:0] s_tdata;
    logic        s_tuser;
    logic        m_tvalid;
    logic        m_tready;
    logic [31:0] m_tdata;
    logic        m_tuser;
    logic        cfg_we;
    logic        cfg_index;
    logic [31:0] cfg_wdata;

    logic [11:0] tbl_x [SEEDS];
    logic [11:0] tbl_y [SEEDS];
    logic [31:0] tbl_color [SEEDS];
    logic [4:0]  reg_count;
    logic [31:0] reg_empty;

    shade_t      shade_q [$];
    plan_row_t   plan [$];
    bit          typed_on;
    shade_t      typed_want;
    bit          src_idle;
    bit          sink_idle;
    int          errors;
    int          cycles;

    nearest_seed_pixel_colorer DUT (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    function automatic shade_t nearest_shade(input logic [11:0] px, input logic [11:0] py);
        shade_t      r;
        logic [24:0] best;
        logic [24:0] d;
        logic [11:0] dx;
        logic [11:0] dy;
        int          n;
        r.color = reg_empty;
        r.found = 1'b0;
        best = '0;
        n = (reg_count > SEEDS) ? SEEDS : reg_count;
        for (int t = 0; t < n; t++) begin
            dx = (px >= tbl_x[t]) ? px - tbl_x[t] : tbl_x[t] - px;
            dy = (py >= tbl_y[t]) ? py - tbl_y[t] : tbl_y[t] - py;
            d = dx * dx + dy * dy;
            if (!r.found || d < best) begin
                best = d;
                r.color = tbl_color[t];
                r.found = 1'b1;
            end
        end
        return r;
    endfunction

    function automatic logic [87:0] pack_item(input logic [3:0] idx, input logic [11:0] sx,
                                              input logic [11:0] sy, input logic [31:0] col,
                                              input logic [11:0] px, input logic [11:0] py);
        return {4'b0000, py, px, col, sy, sx, idx};
    endfunction

    function automatic logic [11:0] pick_coord(input logic [11:0] anchor);
        logic [11:0] off;
        off = 12'($urandom_range(0, 16));
        case ($urandom_range(0, 7))
            0: return 12'd0;
            1: return 12'hFFF;
            2, 3: return anchor + off - 12'd8;
            default: return 12'($urandom);
        endcase
    endfunction

    function automatic plan_row_t pix_row(input logic [11:0] px, input logic [11:0] py,
                                          input bit typed, input logic [31:0] color,
                                          input logic found);
        plan_row_t r;
        r = '0;
        r.kind = nspc_pkg::KIND_PIXEL;
        r.px = px;
        r.py = py;
        r.typed = typed;
        r.want.color = color;
        r.want.found = found;
        return r;
    endfunction

    function automatic plan_row_t seed_row(input logic [3:0] idx, input logic [11:0] sx,
                                           input logic [11:0] sy, input logic [31:0] col);
        plan_row_t r;
        r = '0;
        r.kind = nspc_pkg::KIND_SEED;
        r.idx = idx;
        r.sx = sx;
        r.sy = sy;
        r.col = col;
        return r;
    endfunction

    function automatic plan_row_t reg_row(input logic idx, input logic [31:0] val);
        plan_row_t r;
        r = '0;
        r.is_reg = 1'b1;
        r.reg_idx = idx;
        r.reg_val = val;
        return r;
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] want,
                                   input logic [31:0] got);
        errors++;
        $display("mismatch in %s: expected %h, got %h at cycle %0d", what, want, got, cycles);
    endtask

    task automatic send_item(input logic kind, input logic [87:0] data, input bit typed,
                             input shade_t want);
        int gap;
        gap = src_idle ? $urandom_range(0, 18) : 0;
        if (gap != 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser <= kind;
        s_tdata <= data;
        typed_on = typed;
        typed_want = want;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        @(negedge aclk);
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        while (shade_q.size() != 0) @(negedge aclk);
        repeat (SETTLE) @(negedge aclk);
    endtask

    task automatic write_reg(input logic idx, input logic [31:0] val);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(negedge aclk);
        cfg_we <= 1'b0;
        @(negedge aclk);
    endtask

    always @(posedge aclk) begin
        shade_t      got;
        shade_t      want;
        logic [11:0] px;
        logic [11:0] py;
        cycles++;
        if (cycles >= CYCLE_LIMIT) begin
            $display("status: fail");
            $finish;
        end else if (!aresetn) begin
            reg_count = '0;
            reg_empty = 32'hFF00_0000;
            for (int t = 0; t < SEEDS; t++) begin
                tbl_x[t] = '0;
                tbl_y[t] = '0;
                tbl_color[t] = '0;
            end
        end else begin
            if (cfg_we) begin
                if (cfg_index == nspc_pkg::CFG_SEED_COUNT) begin
                    reg_count = cfg_wdata[4:0];
                end else begin
                    reg_empty = cfg_wdata;
                end
            end
            if (m_tvalid && m_tready) begin
                got.color = m_tdata;
                got.found = m_tuser;
                if (shade_q.size() == 0) begin
                    report_mismatch("result with nothing pending", '0, got.color);
                end else begin
                    want = shade_q.pop_front();
                    if (got.color !== want.color)
                        report_mismatch("pixel_color", want.color, got.color);
                    if (got.found !== want.found)
                        report_mismatch("seed_found", 32'(want.found), 32'(got.found));
                end
            end
            if (s_tvalid && s_tready) begin
                if (s_tuser == nspc_pkg::KIND_SEED) begin
                    if (s_tdata[3:0] < SEEDS) begin
                        tbl_x[s_tdata[3:0]] = s_tdata[15:4];
                        tbl_y[s_tdata[3:0]] = s_tdata[27:16];
                        tbl_color[s_tdata[3:0]] = s_tdata[59:28];
                    end
                end else begin
                    px = s_tdata[71:60];
                    py = s_tdata[83:72];
                    want = nearest_shade(px, py);
                    shade_q.push_back(typed_on ? typed_want : want);
                end
            end
        end
    end

    initial begin
        wait (aresetn === 1'b1);
        @(negedge aclk);
        forever begin
            int gap;
            gap = sink_idle ? $urandom_range(0, 18) : 0;
            if (gap != 0) begin
                m_tready <= 1'b0;
                repeat (gap) @(negedge aclk);
            end
            m_tready <= 1'b1;
            @(posedge aclk);
            while (!m_tvalid) @(posedge aclk);
            @(negedge aclk);
        end
    end

    initial begin
        plan_row_t   row;
        logic [3:0]  idx;
        logic [11:0] sx;
        logic [11:0] sy;
        logic [31:0] cnt;
        logic [31:0] shade;
        int          j;
        aresetn = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tuser = 1'b0;
        m_tready = 1'b0;
        cfg_we = 1'b0;
        cfg_index = 1'b0;
        cfg_wdata = '0;
        typed_on = 1'b0;
        typed_want = '0;
        src_idle = 1'b1;
        sink_idle = 1'b1;
        errors = 0;
        cycles = 0;

        // Reset state: no seeds consulted, so the reset empty color comes back.
        plan.push_back(pix_row(12'd0, 12'd0, 1, 32'hFF00_0000, 1'b0));
        plan.push_back(pix_row(12'hFFF, 12'hFFF, 1, 32'hFF00_0000, 1'b0));
        plan.push_back(reg_row(nspc_pkg::CFG_EMPTY_COLOR, 32'h0000_0000));
        plan.push_back(pix_row(12'd2048, 12'd1, 1, 32'h0000_0000, 1'b0));
        plan.push_back(reg_row(nspc_pkg::CFG_EMPTY_COLOR, 32'hFFFF_FFFF));
        plan.push_back(pix_row(12'hFFF, 12'd0, 1, 32'hFFFF_FFFF, 1'b0));
        plan.push_back(seed_row(4'd0, 12'd0, 12'd0, 32'hAAAA_AAAA));
        plan.push_back(seed_row(4'd1, 12'hFFF, 12'hFFF, 32'h5555_5555));
        plan.push_back(seed_row(4'd2, 12'd100, 12'd100, 32'h1234_5678));
        plan.push_back(seed_row(4'd3, 12'd100, 12'd100, 32'h8765_4321));
        plan.push_back(seed_row(4'd15, 12'hFFF, 12'd0, 32'hFFFF_FFFF));
        plan.push_back(seed_row(4'd14, 12'd0, 12'hFFF, 32'h0000_0000));
        plan.push_back(reg_row(nspc_pkg::CFG_SEED_COUNT, 32'd1));
        plan.push_back(pix_row(12'hFFF, 12'hFFF, 1, 32'hAAAA_AAAA, 1'b1));
        plan.push_back(reg_row(nspc_pkg::CFG_SEED_COUNT, 32'd4));
        plan.push_back(pix_row(12'd0, 12'd0, 1, 32'hAAAA_AAAA, 1'b1));
        plan.push_back(pix_row(12'hFFF, 12'hFFF, 1, 32'h5555_5555, 1'b1));
        // Seeds 2 and 3 share a position, so the lower index must win.
        plan.push_back(pix_row(12'd100, 12'd100, 1, 32'h1234_5678, 1'b1));
        plan.push_back(pix_row(12'd101, 12'd99, 0, '0, 1'b0));
        plan.push_back(pix_row(12'd2047, 12'd2048, 0, '0, 1'b0));
        plan.push_back(reg_row(nspc_pkg::CFG_SEED_COUNT, 32'd0));
        plan.push_back(pix_row(12'd5, 12'd5, 1, 32'hFFFF_FFFF, 1'b0));

        repeat (11) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        foreach (plan[k]) begin
            row = plan[k];
            if (row.is_reg) begin
                drain();
                write_reg(row.reg_idx, row.reg_val);
            end else begin
                send_item(row.kind, pack_item(row.idx, row.sx, row.sy, row.col, row.px, row.py),
                          row.typed, row.want);
            end
        end

        // Every entry is stored before any seed count beyond the directed ones is used.
        for (int k = 0; k < SEEDS; k++) begin
            send_item(nspc_pkg::KIND_SEED,
                      pack_item(4'(k), 12'($urandom), 12'($urandom), $urandom,
                                12'($urandom), 12'($urandom)), 0, '0);
        end

        for (int p = 0; p < PHASES; p++) begin
            drain();
            case (p % 6)
                0: cnt = 32'd31;
                1: cnt = 32'd16;
                2: cnt = 32'd0;
                3: cnt = 32'd1;
                4: cnt = 32'd17;
                default: cnt = $urandom_range(0, 31);
            endcase
            case ($urandom_range(0, 3))
                0: shade = 32'h0000_0000;
                1: shade = 32'hFFFF_FFFF;
                default: shade = $urandom;
            endcase
            write_reg(nspc_pkg::CFG_EMPTY_COLOR, shade);
            write_reg(nspc_pkg::CFG_SEED_COUNT, ($urandom & 32'hFFFF_FFE0) | cnt);
            src_idle = $urandom_range(0, 3) != 0;
            sink_idle = $urandom_range(0, 3) != 0;
            for (int k = 0; k < PHASE_ITEMS; k++) begin
                j = $urandom_range(0, SEEDS - 1);
                if ($urandom_range(0, 3) == 0) begin
                    idx = 4'($urandom);
                    if ($urandom_range(0, 5) == 0) begin
                        sx = tbl_x[j];
                        sy = tbl_y[j];
                    end else begin
                        sx = pick_coord(tbl_x[j]);
                        sy = pick_coord(tbl_y[j]);
                    end
                    send_item(nspc_pkg::KIND_SEED,
                              pack_item(idx, sx, sy, $urandom, 12'($urandom), 12'($urandom)),
                              0, '0);
                end else begin
                    send_item(nspc_pkg::KIND_PIXEL,
                              pack_item(4'($urandom), 12'($urandom), 12'($urandom), $urandom,
                                        pick_coord(tbl_x[j]), pick_coord(tbl_y[j])),
                              0, '0);
                end
            end
        end

        drain();
        if (errors == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end
endmodule
